FILE: design/gsu_pkg.sv
// ----------------------------------------------------------------------------
// gsu_pkg
// shared types, codes and widths of the gjk simplex update core
// ----------------------------------------------------------------------------
package gsu_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_W        = 16;
	localparam int DIR_W          = 62;
	localparam int CNT_W          = 3;
	localparam int S_DATA_W       = 48;
	localparam int S_USER_W       = 1;
	localparam int M_DATA_W       = 192;
	localparam int M_USER_W       = 2;

	typedef enum logic {
		OP_START = 1'b0,
		OP_ADD   = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_CONT = 2'd0,
		ST_SEP  = 2'd1,
		ST_INT  = 2'd2,
		ST_NS   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PT_HOLD   = 3'd0,
		PT_START  = 3'd1,
		PT_PUSH   = 3'd2,
		PT_S1C    = 3'd3,
		PT_SWAP12 = 3'd4,
		PT_ACD    = 3'd5,
		PT_ADB    = 3'd6
	} pt_op_t;

	typedef enum logic [2:0] {
		XA_AB  = 3'd0,
		XA_AC  = 3'd1,
		XA_AD  = 3'd2,
		XA_ABC = 3'd3,
		XA_T   = 3'd4
	} xa_sel_t;

	typedef enum logic [1:0] {
		XB_AB = 2'd0,
		XB_AC = 2'd1,
		XB_AD = 2'd2,
		XB_AO = 2'd3
	} xb_sel_t;

	typedef enum logic [2:0] {
		DA_DIR = 3'd0,
		DA_X   = 3'd1,
		DA_AB  = 3'd2,
		DA_AC  = 3'd3,
		DA_ABC = 3'd4
	} da_sel_t;

	typedef enum logic {
		DB_AO = 1'b0,
		DB_P  = 1'b1
	} db_sel_t;

	typedef enum logic [2:0] {
		DIR_HOLD  = 3'd0,
		DIR_NEGP  = 3'd1,
		DIR_AO    = 3'd2,
		DIR_CROSS = 3'd3,
		DIR_ABC   = 3'd4,
		DIR_NABC  = 3'd5
	} dir_sel_t;

	typedef struct packed {
		logic             cap;
		pt_op_t           pt_op;
		xa_sel_t          xa;
		xb_sel_t          xb;
		logic             ld_x;
		logic             ld_abc;
		logic             ld_t;
		da_sel_t          da;
		db_sel_t          db;
		dir_sel_t         dir_sel;
		logic             out_ld;
		status_t          out_status;
		logic [CNT_W-1:0] out_cnt;
	} dp_cmd_t;

	typedef struct packed {
		logic dot_pos;
		logic dot_neg;
	} dp_stat_t;

endpackage

FILE: design/gjk_simplex_update_core.sv
// ----------------------------------------------------------------------------
// gjk_simplex_update_core
// gjk simplex update: keeps the simplex and search direction of one 3-d test
//
// channel  dir  tdata                                      tuser
// s_axis   in   support_x, support_y, support_z (48 bits)  opcode
// m_axis   out  next_dir_x, next_dir_y, next_dir_z,        status
//               point_count (192 bits)
//
// an item is handled case by case: start, a not-started add, a separated add,
// the line case, the triangle case and the tetrahedron case, each stepped by
// the sequencer issuing cross products and dot sign tests; a new transfer is
// taken only in idle, after the last result is in the output register
// reset clears the sequencer, count, test flag and search direction
// a result waits in the output register while the next transfer is taken;
// the block stalls only when a second result is ready and the first waits
// ----------------------------------------------------------------------------
module gjk_simplex_update_core #(
	parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gsu_pkg::S_DATA_W-1:0]  s_tdata,  // support_x, support_y, support_z
	input  logic [gsu_pkg::S_USER_W-1:0]  s_tuser,  // opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gsu_pkg::M_DATA_W-1:0]  m_tdata,  // next_dir_x, next_dir_y, next_dir_z,
	                                                // point_count
	output logic [gsu_pkg::M_USER_W-1:0]  m_tuser   // status
);
	import gsu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	gsu_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

FILE: design/gsu_dp.sv
// ----------------------------------------------------------------------------
// gsu_dp
// simplex store, cross product unit, dot sign unit and result register
// ----------------------------------------------------------------------------
module gsu_dp #(
	parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gsu_pkg::dp_cmd_t           cmd,
	output gsu_pkg::dp_stat_t          stat,
	input  logic [gsu_pkg::S_DATA_W-1:0] s_tdata,
	output logic [gsu_pkg::M_DATA_W-1:0] m_tdata,
	output logic [gsu_pkg::M_USER_W-1:0] m_tuser
);
	import gsu_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int EW = C + 1;
	localparam int PW = 2 * C + 3;
	localparam int XW = 3 * C + 5;
	localparam int DW = (XW > 64) ? 64 : XW;
	localparam int SW = DW + EW + 2;

	logic signed [C-1:0]  p_q   [3];
	logic signed [C-1:0]  pt_q  [4][3];
	logic signed [DW-1:0] dir_q [3];
	logic signed [DW-1:0] x_q   [3];
	logic signed [PW-1:0] abc_q [3];
	logic signed [PW-1:0] t_q   [3];

	logic signed [EW-1:0] ab [3];
	logic signed [EW-1:0] ac [3];
	logic signed [EW-1:0] ad [3];
	logic signed [EW-1:0] ao [3];

	logic signed [PW-1:0]    xa [3];
	logic signed [EW-1:0]    xb [3];
	logic signed [PW+EW-1:0] xm [6];
	logic signed [XW-1:0]    cr [3];

	logic signed [DW-1:0]    va [3];
	logic signed [EW-1:0]    vb [3];
	logic signed [DW+EW-1:0] vm [3];
	logic signed [SW-1:0]    vsum;

	logic [C+FIELD_W-1:0] raw [3];
	logic signed [C-1:0]  pin [3];

	logic [DIR_W-1:0]  odir_q [3];
	logic [1:0]        ostat_q;
	logic [CNT_W-1:0]  ocnt_q;
	logic signed [63:0] dwide [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			raw[i] = {{C{1'b0}}, s_tdata[FIELD_W*i +: FIELD_W]};
			pin[i] = raw[i][C-1:0];
			ab[i]  = EW'(pt_q[1][i]) - EW'(pt_q[0][i]);
			ac[i]  = EW'(pt_q[2][i]) - EW'(pt_q[0][i]);
			ad[i]  = EW'(pt_q[3][i]) - EW'(pt_q[0][i]);
			ao[i]  = -EW'(pt_q[0][i]);
		end
	end

	// cross product, wide first operand by narrow second operand
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cmd.xa)
				XA_AB:   xa[i] = PW'(ab[i]);
				XA_AC:   xa[i] = PW'(ac[i]);
				XA_AD:   xa[i] = PW'(ad[i]);
				XA_ABC:  xa[i] = abc_q[i];
				XA_T:    xa[i] = t_q[i];
				default: xa[i] = '0;
			endcase
			case (cmd.xb)
				XB_AB:   xb[i] = ab[i];
				XB_AC:   xb[i] = ac[i];
				XB_AD:   xb[i] = ad[i];
				XB_AO:   xb[i] = ao[i];
				default: xb[i] = '0;
			endcase
		end
		xm[0] = xa[1] * xb[2];
		xm[1] = xa[2] * xb[1];
		xm[2] = xa[2] * xb[0];
		xm[3] = xa[0] * xb[2];
		xm[4] = xa[0] * xb[1];
		xm[5] = xa[1] * xb[0];
		cr[0] = XW'(xm[0]) - XW'(xm[1]);
		cr[1] = XW'(xm[2]) - XW'(xm[3]);
		cr[2] = XW'(xm[4]) - XW'(xm[5]);
	end

	// dot product sign
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cmd.da)
				DA_DIR:  va[i] = dir_q[i];
				DA_X:    va[i] = x_q[i];
				DA_AB:   va[i] = DW'(ab[i]);
				DA_AC:   va[i] = DW'(ac[i]);
				DA_ABC:  va[i] = DW'(abc_q[i]);
				default: va[i] = '0;
			endcase
			case (cmd.db)
				DB_AO:   vb[i] = ao[i];
				DB_P:    vb[i] = EW'(p_q[i]);
				default: vb[i] = '0;
			endcase
			vm[i] = va[i] * vb[i];
		end
		vsum = SW'(vm[0]) + SW'(vm[1]) + SW'(vm[2]);
		stat.dot_neg = vsum[SW-1];
		stat.dot_pos = !vsum[SW-1] && (vsum != '0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.cap) begin
				p_q[i] <= pin[i];
			end
			case (cmd.pt_op)
				PT_START: begin
					pt_q[0][i] <= p_q[i];
				end
				PT_PUSH: begin
					pt_q[3][i] <= pt_q[2][i];
					pt_q[2][i] <= pt_q[1][i];
					pt_q[1][i] <= pt_q[0][i];
					pt_q[0][i] <= p_q[i];
				end
				PT_S1C: begin
					pt_q[1][i] <= pt_q[2][i];
				end
				PT_SWAP12: begin
					pt_q[1][i] <= pt_q[2][i];
					pt_q[2][i] <= pt_q[1][i];
				end
				PT_ACD: begin
					pt_q[1][i] <= pt_q[2][i];
					pt_q[2][i] <= pt_q[3][i];
				end
				PT_ADB: begin
					pt_q[1][i] <= pt_q[3][i];
					pt_q[2][i] <= pt_q[1][i];
				end
				default: begin
				end
			endcase
			if (cmd.ld_x) begin
				x_q[i] <= DW'(cr[i]);
			end
			if (cmd.ld_abc) begin
				abc_q[i] <= PW'(cr[i]);
			end
			if (cmd.ld_t) begin
				t_q[i] <= PW'(cr[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				dir_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				case (cmd.dir_sel)
					DIR_NEGP:  dir_q[i] <= -DW'(p_q[i]);
					DIR_AO:    dir_q[i] <= DW'(ao[i]);
					DIR_CROSS: dir_q[i] <= DW'(cr[i]);
					DIR_ABC:   dir_q[i] <= DW'(abc_q[i]);
					DIR_NABC:  dir_q[i] <= -DW'(abc_q[i]);
					default:   dir_q[i] <= dir_q[i];
				endcase
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dwide[i] = 64'(dir_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			for (int i = 0; i < 3; i++) begin
				odir_q[i] <= (cmd.out_status == ST_CONT) ? dwide[i][DIR_W-1:0] : '0;
			end
			ostat_q <= cmd.out_status;
			ocnt_q  <= cmd.out_cnt;
		end
	end

	assign m_tdata = {3'b000, ocnt_q, odir_q[2], odir_q[1], odir_q[0]};
	assign m_tuser = ostat_q;

endmodule

FILE: design/gsu_ctrl.sv
// ----------------------------------------------------------------------------
// gsu_ctrl
// sequencer for start, push and the line, triangle and tetrahedron cases
// ----------------------------------------------------------------------------
module gsu_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gsu_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output gsu_pkg::dp_cmd_t              cmd,
	input  gsu_pkg::dp_stat_t             stat
);
	import gsu_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE = 19'h00001,
		S_ST   = 19'h00002,
		S_CHK  = 19'h00004,
		S_L1   = 19'h00008,
		S_L3   = 19'h00010,
		S_T1   = 19'h00020,
		S_T2   = 19'h00040,
		S_T3   = 19'h00080,
		S_T4   = 19'h00100,
		S_T5   = 19'h00200,
		S_T6   = 19'h00400,
		S_T7   = 19'h00800,
		S_Q1   = 19'h01000,
		S_Q2   = 19'h02000,
		S_Q3   = 19'h04000,
		S_Q4   = 19'h08000,
		S_Q5   = 19'h10000,
		S_Q6   = 19'h20000,
		S_RESP = 19'h40000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             act_q, act_d;
	status_t          stat_q, stat_d;
	logic             mvalid_q, mvalid_d;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mvalid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cnt_d    = cnt_q;
		act_d    = act_q;
		stat_d   = stat_q;
		mvalid_d = mvalid_q && !m_tready;
		cmd.out_status = stat_q;
		cmd.out_cnt    = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					if (s_tuser[0] == OP_START) begin
						state_d = S_ST;
					end else if (!act_q) begin
						stat_d  = ST_NS;
						state_d = S_RESP;
					end else begin
						state_d = S_CHK;
					end
				end
			end
			S_ST: begin
				cmd.pt_op   = PT_START;
				cmd.dir_sel = DIR_NEGP;
				cnt_d   = CNT_W'(1);
				act_d   = 1'b1;
				stat_d  = ST_CONT;
				state_d = S_RESP;
			end
			S_CHK: begin
				cmd.da = DA_DIR;
				cmd.db = DB_P;
				if (!stat.dot_pos) begin
					act_d   = 1'b0;
					stat_d  = ST_SEP;
					state_d = S_RESP;
				end else begin
					cmd.pt_op = PT_PUSH;
					cnt_d = (cnt_q >= CNT_W'(3)) ? CNT_W'(4) : cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_d = S_L1;
					end else if (cnt_q == CNT_W'(2)) begin
						state_d = S_T1;
					end else begin
						state_d = S_Q1;
					end
				end
			end
			S_L1: begin
				cmd.da = DA_AB;
				cmd.db = DB_AO;
				if (stat.dot_pos) begin
					cmd.xa   = XA_AB;
					cmd.xb   = XB_AO;
					cmd.ld_t = 1'b1;
					state_d  = S_L3;
				end else begin
					cmd.dir_sel = DIR_AO;
					cnt_d   = CNT_W'(1);
					stat_d  = ST_CONT;
					state_d = S_RESP;
				end
			end
			S_L3: begin
				cmd.xa      = XA_T;
				cmd.xb      = XB_AB;
				cmd.dir_sel = DIR_CROSS;
				cnt_d   = CNT_W'(2);
				stat_d  = ST_CONT;
				state_d = S_RESP;
			end
			S_T1: begin
				cmd.xa     = XA_AB;
				cmd.xb     = XB_AC;
				cmd.ld_abc = 1'b1;
				state_d    = S_T2;
			end
			S_T2: begin
				cmd.xa   = XA_ABC;
				cmd.xb   = XB_AC;
				cmd.ld_x = 1'b1;
				state_d  = S_T3;
			end
			S_T3: begin
				cmd.da  = DA_X;
				cmd.db  = DB_AO;
				state_d = stat.dot_pos ? S_T4 : S_T5;
			end
			S_T4: begin
				cmd.da = DA_AC;
				cmd.db = DB_AO;
				if (stat.dot_pos) begin
					cmd.pt_op = PT_S1C;
				end
				cnt_d   = CNT_W'(2);
				state_d = S_L1;
			end
			S_T5: begin
				cmd.xa   = XA_ABC;
				cmd.xb   = XB_AB;
				cmd.ld_x = 1'b1;
				state_d  = S_T6;
			end
			S_T6: begin
				cmd.da = DA_X;
				cmd.db = DB_AO;
				if (stat.dot_neg) begin
					cnt_d   = CNT_W'(2);
					state_d = S_L1;
				end else begin
					state_d = S_T7;
				end
			end
			S_T7: begin
				cmd.da = DA_ABC;
				cmd.db = DB_AO;
				if (stat.dot_pos) begin
					cmd.dir_sel = DIR_ABC;
				end else begin
					cmd.pt_op   = PT_SWAP12;
					cmd.dir_sel = DIR_NABC;
				end
				cnt_d   = CNT_W'(3);
				stat_d  = ST_CONT;
				state_d = S_RESP;
			end
			S_Q1: begin
				cmd.xa   = XA_AB;
				cmd.xb   = XB_AC;
				cmd.ld_x = 1'b1;
				state_d  = S_Q2;
			end
			S_Q2: begin
				cmd.da = DA_X;
				cmd.db = DB_AO;
				if (stat.dot_pos) begin
					cnt_d   = CNT_W'(3);
					state_d = S_T1;
				end else begin
					state_d = S_Q3;
				end
			end
			S_Q3: begin
				cmd.xa   = XA_AC;
				cmd.xb   = XB_AD;
				cmd.ld_x = 1'b1;
				state_d  = S_Q4;
			end
			S_Q4: begin
				cmd.da = DA_X;
				cmd.db = DB_AO;
				if (stat.dot_pos) begin
					cmd.pt_op = PT_ACD;
					cnt_d     = CNT_W'(3);
					state_d   = S_T1;
				end else begin
					state_d = S_Q5;
				end
			end
			S_Q5: begin
				cmd.xa   = XA_AD;
				cmd.xb   = XB_AB;
				cmd.ld_x = 1'b1;
				state_d  = S_Q6;
			end
			S_Q6: begin
				cmd.da = DA_X;
				cmd.db = DB_AO;
				if (stat.dot_pos) begin
					cmd.pt_op = PT_ADB;
					cnt_d     = CNT_W'(3);
					state_d   = S_T1;
				end else begin
					cnt_d   = CNT_W'(4);
					act_d   = 1'b0;
					stat_d  = ST_INT;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!mvalid_q || m_tready) begin
					cmd.out_ld = 1'b1;
					mvalid_d   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			act_q    <= 1'b0;
			stat_q   <= ST_CONT;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			act_q    <= act_d;
			stat_q   <= stat_d;
			mvalid_q <= mvalid_d;
		end
	end

endmodule

FILE: design/gsu_chk.sv
// ----------------------------------------------------------------------------
// gsu_chk
// port checks for the gjk simplex update core
// ----------------------------------------------------------------------------
module gsu_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [gsu_pkg::S_DATA_W-1:0]  s_tdata,
	input logic [gsu_pkg::S_USER_W-1:0]  s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [gsu_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [gsu_pkg::M_USER_W-1:0]  m_tuser
);
	import gsu_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_int_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_INT |-> m_tdata[185:0] == '0 && m_tdata[188:186] == 3'd4)
		else $error("intersecting result malformed");

	a_sep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_SEP || m_tuser == ST_NS) |-> m_tdata[185:0] == '0)
		else $error("nonzero direction on ended test");

	a_cont_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_CONT |-> m_tdata[188:186] != 3'd0 && m_tdata[188:186] != 3'd4
			&& m_tdata[188] == 1'b0)
		else $error("bad point count on continue");

endmodule

bind gjk_simplex_update_core gsu_chk u_gsu_chk (.*);

FILE: tb/gjk_simplex_update_core_tb.sv
// ----------------------------------------------------------------------------
// gjk_simplex_update_core_tb
// self-checking bench: directed table then constrained-by-hand random gjk
// sequences, results checked against table values or an in-bench simplex predictor
// ----------------------------------------------------------------------------
module gjk_simplex_update_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gsu_pkg::*;

	typedef struct {
		longint x, y, z;
	} vec_t;

	typedef struct {
		longint   dx, dy, dz;
		status_t  st;
		logic [2:0] cnt;
	} step_res_t;

	typedef struct {
		opcode_t    op;
		int         x, y, z;
		bit         typed;
		step_res_t  res;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic [S_USER_W-1:0]  s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic [M_USER_W-1:0]  m_tuser;

	gjk_simplex_update_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state
	vec_t        pts [4];
	int unsigned kept;
	vec_t        sdir;
	bit          active;
	vec_t        nd;

	step_res_t   pending_res [$];
	int          errors;
	int          status_seen [4];
	int          send_idle, recv_idle;
	bit          pressure_go;
	bit          pressure_done;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic vec_t vsub(vec_t a, vec_t b);
		vec_t r;
		r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
		return r;
	endfunction

	function automatic vec_t vneg(vec_t a);
		vec_t r;
		r.x = -a.x; r.y = -a.y; r.z = -a.z;
		return r;
	endfunction

	function automatic vec_t vcross(vec_t a, vec_t b);
		vec_t r;
		r.x = a.y * b.z - a.z * b.y;
		r.y = a.z * b.x - a.x * b.z;
		r.z = a.x * b.y - a.y * b.x;
		return r;
	endfunction

	function automatic logic signed [127:0] wide(longint v);
		logic signed [127:0] w;
		w = v;
		return w;
	endfunction

	function automatic bit same_dir(vec_t a, vec_t b);
		logic signed [127:0] s;
		s = wide(a.x) * wide(b.x) + wide(a.y) * wide(b.y) + wide(a.z) * wide(b.z);
		return s > 0;
	endfunction

	function automatic void line_case();
		vec_t ab, ao;
		ab = vsub(pts[1], pts[0]);
		ao = vneg(pts[0]);
		if (same_dir(ab, ao)) begin
			kept = 2;
			nd = vcross(vcross(ab, ao), ab);
		end else begin
			kept = 1;
			nd = ao;
		end
	endfunction

	function automatic void triangle_case();
		vec_t a, b, c, ab, ac, ao, abc;
		a = pts[0]; b = pts[1]; c = pts[2];
		ab = vsub(b, a); ac = vsub(c, a); ao = vneg(a);
		abc = vcross(ab, ac);
		if (same_dir(vcross(abc, ac), ao)) begin
			if (same_dir(ac, ao)) begin
				pts[1] = c;
				kept = 2;
				nd = vcross(vcross(ac, ao), ac);
			end else begin
				kept = 2;
				line_case();
			end
		end else if (same_dir(vcross(ab, abc), ao)) begin
			kept = 2;
			line_case();
		end else begin
			kept = 3;
			if (same_dir(abc, ao)) begin
				nd = abc;
			end else begin
				pts[1] = c;
				pts[2] = b;
				nd = vneg(abc);
			end
		end
	endfunction

	function automatic bit tetra_case();
		vec_t a, b, c, e, ab, ac, ad, ao;
		a = pts[0]; b = pts[1]; c = pts[2]; e = pts[3];
		ab = vsub(b, a); ac = vsub(c, a); ad = vsub(e, a); ao = vneg(a);
		if (same_dir(vcross(ab, ac), ao)) begin
			kept = 3;
			triangle_case();
			return 1'b0;
		end
		if (same_dir(vcross(ac, ad), ao)) begin
			pts[1] = c; pts[2] = e; kept = 3;
			triangle_case();
			return 1'b0;
		end
		if (same_dir(vcross(ad, ab), ao)) begin
			pts[1] = e; pts[2] = b; kept = 3;
			triangle_case();
			return 1'b0;
		end
		kept = 4;
		return 1'b1;
	endfunction

	function automatic step_res_t simplex_step(opcode_t op, vec_t p);
		step_res_t r;
		int unsigned n;
		bit hit;
		nd = '{0, 0, 0};
		if (op == OP_START) begin
			pts[0] = p;
			kept = 1;
			active = 1'b1;
			nd = vneg(p);
			sdir = nd;
			r.st = ST_CONT;
		end else if (!active) begin
			r.st = ST_NS;
		end else if (!same_dir(p, sdir)) begin
			active = 1'b0;
			r.st = ST_SEP;
		end else begin
			n = (kept > 3) ? 3 : kept;
			for (int i = n; i > 0; i--)
				pts[i] = pts[i-1];
			pts[0] = p;
			n++;
			hit = 1'b0;
			if (n == 2) begin
				line_case();
			end else if (n == 3) begin
				triangle_case();
			end else begin
				hit = tetra_case();
			end
			if (hit) begin
				active = 1'b0;
				nd = '{0, 0, 0};
				r.st = ST_INT;
			end else begin
				sdir = nd;
				r.st = ST_CONT;
			end
		end
		r.dx = nd.x; r.dy = nd.y; r.dz = nd.z;
		r.cnt = kept[2:0];
		return r;
	endfunction

	task automatic send_point(opcode_t op, int x, int y, int z, bit typed, step_res_t tres);
		vec_t p;
		step_res_t r;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {z[15:0], y[15:0], x[15:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		p.x = longint'(16'(x) ^ 16'h8000) - 32768;
		p.y = longint'(16'(y) ^ 16'h8000) - 32768;
		p.z = longint'(16'(z) ^ 16'h8000) - 32768;
		r = simplex_step(op, p);
		pending_res.push_back(typed ? tres : r);
	endtask

	// receiver with optional long hold-off
	initial begin
		int hold;
		m_tready = 1'b0;
		pressure_done = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (pressure_go && !pressure_done) begin
				pressure_done = 1'b1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// result check
	initial begin
		step_res_t e;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_res.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					e = pending_res.pop_front();
					status_seen[m_tuser]++;
					if (m_tdata[61:0] !== e.dx[61:0]) begin
						$error("next_dir_x exp %h got %h", e.dx[61:0], m_tdata[61:0]);
						errors++;
					end
					if (m_tdata[123:62] !== e.dy[61:0]) begin
						$error("next_dir_y exp %h got %h", e.dy[61:0], m_tdata[123:62]);
						errors++;
					end
					if (m_tdata[185:124] !== e.dz[61:0]) begin
						$error("next_dir_z exp %h got %h", e.dz[61:0], m_tdata[185:124]);
						errors++;
					end
					if (m_tdata[188:186] !== e.cnt) begin
						$error("point_count exp %0d got %0d", e.cnt, m_tdata[188:186]);
						errors++;
					end
					if (m_tuser !== e.st) begin
						$error("status exp %0d got %0d", e.st, m_tuser);
						errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 3000) begin
				$display("gjk_simplex_update_core test failed");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t  rows [$];
		step_res_t z0;
		vec_t      p;
		logic signed [127:0] dt;
		int        px, py, pz;
		opcode_t   op;

		errors = 0;
		pressure_go = 1'b0;
		send_idle = 22;
		recv_idle = 52;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		z0 = '{0, 0, 0, ST_NS, 3'd0};
		rows.push_back('{OP_ADD, 256, 256, 256, 1'b1, z0});
		rows.push_back('{OP_START, 0, 0, 0, 1'b1, '{0, 0, 0, ST_CONT, 3'd1}});
		rows.push_back('{OP_ADD, 256, 256, 256, 1'b1, '{0, 0, 0, ST_SEP, 3'd1}});
		rows.push_back('{OP_ADD, 256, 256, 256, 1'b1, '{0, 0, 0, ST_NS, 3'd1}});
		rows.push_back('{OP_START, -32768, -32768, -32768, 1'b1,
			'{32768, 32768, 32768, ST_CONT, 3'd1}});
		rows.push_back('{OP_START, 32767, 32767, 32767, 1'b1,
			'{-32767, -32767, -32767, ST_CONT, 3'd1}});
		rows.push_back('{OP_ADD, -32768, -32768, -32768, 1'b0, z0});
		rows.push_back('{OP_ADD, -32768, 32767, 0, 1'b0, z0});
		rows.push_back('{OP_ADD, 0, -32768, 32767, 1'b0, z0});
		rows.push_back('{OP_ADD, 32767, -32768, -32768, 1'b0, z0});
		rows.push_back('{OP_START, 256, 0, 0, 1'b1, '{-256, 0, 0, ST_CONT, 3'd1}});
		rows.push_back('{OP_ADD, -256, 256, 0, 1'b0, z0});
		rows.push_back('{OP_ADD, -256, -256, 256, 1'b0, z0});
		rows.push_back('{OP_ADD, -256, -256, -256, 1'b0, z0});
		rows.push_back('{OP_ADD, 0, 0, -512, 1'b0, z0});
		rows.push_back('{OP_ADD, 0, 512, 0, 1'b0, z0});
		rows.push_back('{OP_START, 512, 512, 0, 1'b0, z0});
		rows.push_back('{OP_ADD, -512, -512, 0, 1'b0, z0});
		rows.push_back('{OP_ADD, 0, 0, 512, 1'b0, z0});
		foreach (rows[i])
			send_point(rows[i].op, rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle = 52; recv_idle = 22;
			end else if (ph == 2) begin
				send_idle = 0; recv_idle = 0;
				pressure_go = 1'b1;
			end
			for (int k = 0; k < 184; k++) begin
				if ($urandom_range(99) < 12) begin
					px = $urandom_range(65535); py = $urandom_range(65535);
					pz = $urandom_range(65535);
					op = opcode_t'($urandom_range(1));
				end else begin
					if (!active && $urandom_range(99) < 85)
						op = OP_START;
					else
						op = OP_ADD;
					px = int'($urandom_range(32767)) - 16384;
					py = int'($urandom_range(32767)) - 16384;
					pz = int'($urandom_range(32767)) - 16384;
					if (op == OP_ADD) begin
						p = '{px, py, pz};
						dt = wide(p.x) * wide(sdir.x) + wide(p.y) * wide(sdir.y)
							+ wide(p.z) * wide(sdir.z);
						if (dt < 0) begin
							px = -px; py = -py; pz = -pz;
						end
					end
				end
				send_point(op, px, py, pz, 1'b0, z0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_res.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("ran 19 directed and 552 random steps, statuses seen: continue %0d,",
			status_seen[ST_CONT]);
		$display("  separated %0d, intersecting %0d, not started %0d, with a long output stall",
			status_seen[ST_SEP], status_seen[ST_INT], status_seen[ST_NS]);
		if (errors == 0) begin
			$display("gjk_simplex_update_core test passed");
		end else begin
			$display("gjk_simplex_update_core test failed");
		end
		$finish;
	end

endmodule

FILE: files.f
design/gsu_pkg.sv
design/gsu_dp.sv
design/gsu_ctrl.sv
design/gjk_simplex_update_core.sv
design/gsu_chk.sv
tb/gjk_simplex_update_core_tb.sv
